// ===== design/spt_pkg.sv =====
// Package for the segment protection table: codes, sizes and entry types.
`timescale 1ns / 1ps

package spt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned SEL_W    = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PRIV_W   = 8;
  localparam int unsigned PERM_W   = 8;
  localparam int unsigned FIDX_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 4;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  // Per-entry fields other than the selector
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
    logic [PRIV_W-1:0] priv;
    logic [PERM_W-1:0] perm;
  } attr_t;

  // Write enables from the sequencer to the table
  typedef struct packed {
    logic sel_we;
    logic attr_we;
  } tbl_wr_t;

endpackage

// ===== design/segment_protection_table.sv =====
// Top level of the segment protection table: sequencer plus entry storage.
`timescale 1ns / 1ps

// Segment protection table.
// Input channel: drive the in_ fields and raise start; an item is taken at a
// rising edge with start high and busy low. busy stays high while the item is
// worked on. Result channel: out_valid pulses for exactly one cycle with
// out_status, out_entry_index and out_access_granted; the receiver cannot
// stall it and must take the result in that cycle.
// Clear, free, unknown codes, allocate into a full or empty table, and
// lookups in an empty table are decided in the decide state, which loads
// the result registers. Allocate, check and find otherwise scan entries
// 0 .. count-1 through one registered memory read port and one selector
// comparator, one entry per cycle, and stop at the first hit or after the
// last entry. A new item may be started on the cycle the result strobe is
// shown.
// Reset (rst_n low, synchronous) empties the table by zeroing the fill count;
// entries beyond the count are never compared, so no clearing pass is run.
module segment_protection_table #(
  parameter int unsigned MAX_ENTRIES = spt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [spt_pkg::CMD_W-1:0]       in_command,
  input  logic [spt_pkg::SEL_W-1:0]       in_seg_selector,
  input  logic [spt_pkg::ADDR_W-1:0]      in_seg_base,
  input  logic [spt_pkg::ADDR_W-1:0]      in_seg_limit,
  input  logic [spt_pkg::PRIV_W-1:0]      in_entry_privilege,
  input  logic [spt_pkg::PERM_W-1:0]      in_entry_permissions,
  input  logic [spt_pkg::PRIV_W-1:0]      in_process_privilege,
  input  logic [spt_pkg::PERM_W-1:0]      in_access_bits,
  input  logic [spt_pkg::FIDX_W-1:0]      in_free_index,
  output logic                            out_valid,
  output logic [spt_pkg::STATUS_W-1:0]    out_status,
  output logic [spt_pkg::INDEX_W-1:0]     out_entry_index,
  output logic                            out_access_granted
);

  // table address width
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  spt_pkg::tbl_wr_t           tbl_wr;
  logic [AW-1:0]              tbl_waddr;
  logic [AW-1:0]              tbl_raddr;
  logic [spt_pkg::SEL_W-1:0]  tbl_wsel;
  logic [spt_pkg::SEL_W-1:0]  tbl_rsel;
  spt_pkg::attr_t             tbl_wattr;
  spt_pkg::attr_t             tbl_rattr;

  // Sequencer: latch the item, decide simple commands at once, else scan
  spt_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_seg_selector      (in_seg_selector),
    .in_seg_base          (in_seg_base),
    .in_seg_limit         (in_seg_limit),
    .in_entry_privilege   (in_entry_privilege),
    .in_entry_permissions (in_entry_permissions),
    .in_process_privilege (in_process_privilege),
    .in_access_bits       (in_access_bits),
    .in_free_index        (in_free_index),
    .tbl_wr               (tbl_wr),
    .tbl_waddr            (tbl_waddr),
    .tbl_wsel             (tbl_wsel),
    .tbl_wattr            (tbl_wattr),
    .tbl_raddr            (tbl_raddr),
    .tbl_rsel             (tbl_rsel),
    .tbl_rattr            (tbl_rattr),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_entry_index      (out_entry_index),
    .out_access_granted   (out_access_granted)
  );

  // Entry storage: selectors apart from attributes so free touches only the selector
  spt_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .wr    (tbl_wr),
    .waddr (tbl_waddr),
    .wsel  (tbl_wsel),
    .wattr (tbl_wattr),
    .raddr (tbl_raddr),
    .rsel  (tbl_rsel),
    .rattr (tbl_rattr)
  );

endmodule

// ===== design/spt_table.sv =====
// Entry storage: selector and attribute memories, one write and one registered read port.
`timescale 1ns / 1ps

module spt_table #(
  parameter int unsigned MAX_ENTRIES = spt_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                         clk,
  input  spt_pkg::tbl_wr_t             wr,
  input  logic [AW-1:0]                waddr,
  input  logic [spt_pkg::SEL_W-1:0]    wsel,
  input  spt_pkg::attr_t               wattr,
  input  logic [AW-1:0]                raddr,
  output logic [spt_pkg::SEL_W-1:0]    rsel,
  output spt_pkg::attr_t               rattr
);

  logic [spt_pkg::SEL_W-1:0] sel_mem [MAX_ENTRIES];
  spt_pkg::attr_t            attr_mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.sel_we) begin
      sel_mem[waddr] <= wsel;
    end
    rsel <= sel_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.attr_we) begin
      attr_mem[waddr] <= wattr;
    end
    rattr <= attr_mem[raddr];
  end

endmodule

// ===== design/spt_ctrl.sv =====
// Command sequencer: decodes commands, scans the table with one compare unit, forms results.
`timescale 1ns / 1ps

module spt_ctrl #(
  parameter int unsigned MAX_ENTRIES = spt_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [spt_pkg::CMD_W-1:0]       in_command,
  input  logic [spt_pkg::SEL_W-1:0]       in_seg_selector,
  input  logic [spt_pkg::ADDR_W-1:0]      in_seg_base,
  input  logic [spt_pkg::ADDR_W-1:0]      in_seg_limit,
  input  logic [spt_pkg::PRIV_W-1:0]      in_entry_privilege,
  input  logic [spt_pkg::PERM_W-1:0]      in_entry_permissions,
  input  logic [spt_pkg::PRIV_W-1:0]      in_process_privilege,
  input  logic [spt_pkg::PERM_W-1:0]      in_access_bits,
  input  logic [spt_pkg::FIDX_W-1:0]      in_free_index,
  output spt_pkg::tbl_wr_t                tbl_wr,
  output logic [AW-1:0]                   tbl_waddr,
  output logic [spt_pkg::SEL_W-1:0]       tbl_wsel,
  output spt_pkg::attr_t                  tbl_wattr,
  output logic [AW-1:0]                   tbl_raddr,
  input  logic [spt_pkg::SEL_W-1:0]       tbl_rsel,
  input  spt_pkg::attr_t                  tbl_rattr,
  output logic                            out_valid,
  output logic [spt_pkg::STATUS_W-1:0]    out_status,
  output logic [spt_pkg::INDEX_W-1:0]     out_entry_index,
  output logic                            out_access_granted
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned XW = (CW > spt_pkg::FIDX_W) ? CW : spt_pkg::FIDX_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_SCAN   = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [spt_pkg::CMD_W-1:0]       cmd_r;
  logic [spt_pkg::SEL_W-1:0]       sel_r;
  spt_pkg::attr_t                  attr_r;
  logic [spt_pkg::PRIV_W-1:0]      ppriv_r;
  logic [spt_pkg::PERM_W-1:0]      acc_r;
  logic [spt_pkg::FIDX_W-1:0]      fidx_r;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                   pidx_r, pidx_nxt;
  logic                            pv_r, pv_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [spt_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [spt_pkg::INDEX_W-1:0]     index_r;
  logic                            grant_r, grant_nxt;
  logic [CW-1:0]                   index_sel;
  logic [CW+spt_pkg::INDEX_W-1:0]  index_ext;
  logic                            hit, last, accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign tbl_raddr = idx_r[AW-1:0];
  assign hit       = pv_r && (tbl_rsel == sel_r);
  assign last      = pv_r && ((pidx_r + CW'(1)) == count_r);
  assign index_ext = {{spt_pkg::INDEX_W{1'b0}}, index_sel};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    pv_nxt        = 1'b0;
    out_valid_nxt = 1'b0;
    status_nxt    = spt_pkg::ST_OK;
    index_sel     = '0;
    grant_nxt     = 1'b0;
    tbl_wr        = '0;
    tbl_waddr     = count_r[AW-1:0];
    tbl_wsel      = sel_r;
    tbl_wattr     = attr_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (cmd_r)
          spt_pkg::CMD_CLEAR: begin
            count_nxt = '0;
          end
          spt_pkg::CMD_ALLOC: begin
            if (count_r == CW'(MAX_ENTRIES)) begin
              status_nxt = spt_pkg::ST_FULL;
            end else if (count_r == '0) begin
              tbl_wr.sel_we  = 1'b1;
              tbl_wr.attr_we = 1'b1;
              count_nxt      = CW'(1);
            end else begin
              state_nxt     = S_SCAN;
              out_valid_nxt = 1'b0;
              idx_nxt       = '0;
            end
          end
          spt_pkg::CMD_CHECK, spt_pkg::CMD_FIND: begin
            if (count_r == '0) begin
              status_nxt = spt_pkg::ST_NOTFOUND;
            end else begin
              state_nxt     = S_SCAN;
              out_valid_nxt = 1'b0;
              idx_nxt       = '0;
            end
          end
          spt_pkg::CMD_FREE: begin
            if (XW'(fidx_r) < XW'(count_r)) begin
              tbl_wr.sel_we = 1'b1;
              tbl_waddr     = fidx_r[AW-1:0];
              tbl_wsel      = '0;
            end else begin
              status_nxt = spt_pkg::ST_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // issue the next read while the previous entry is compared
        if (idx_r < count_r) begin
          idx_nxt  = idx_r + CW'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r;
        end
        if (hit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          pv_nxt        = 1'b0;
          case (cmd_r)
            spt_pkg::CMD_ALLOC: begin
              status_nxt = spt_pkg::ST_DUP;
            end
            spt_pkg::CMD_CHECK: begin
              index_sel = pidx_r;
              grant_nxt = (ppriv_r >= tbl_rattr.priv) &&
                          ((tbl_rattr.perm & acc_r) == acc_r);
            end
            default: begin
              index_sel = pidx_r;
            end
          endcase
        end else if (last) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          pv_nxt        = 1'b0;
          if (cmd_r == spt_pkg::CMD_ALLOC) begin
            tbl_wr.sel_we  = 1'b1;
            tbl_wr.attr_we = 1'b1;
            index_sel      = count_r;
            count_nxt      = count_r + CW'(1);
          end else begin
            status_nxt = spt_pkg::ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_command;
      sel_r       <= in_seg_selector;
      attr_r      <= '{base: in_seg_base, limit: in_seg_limit,
                       priv: in_entry_privilege, perm: in_entry_permissions};
      ppriv_r     <= in_process_privilege;
      acc_r       <= in_access_bits;
      fidx_r      <= in_free_index;
    end
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    status_r <= status_nxt;
    index_r  <= index_ext[spt_pkg::INDEX_W-1:0];
    grant_r  <= grant_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_entry_index    = index_r;
  assign out_access_granted = grant_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while still working");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (pidx_r < count_r))
    else $error("compared entry beyond fill count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && cmd_r == spt_pkg::CMD_CLEAR) |=>
      (count_r == '0 && out_valid_r))
    else $error("clear did not empty the table");

  a_grant_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && grant_r) |-> (status_r == spt_pkg::ST_OK))
    else $error("access granted with error status");

endmodule

// ===== dv/segment_protection_table_tb.sv =====
// Testbench for the segment protection table: directed table plus random command traffic.
`timescale 1ns / 1ps

// Drive commands into the segment protection table through the start/busy
// handshake. Keep a shadow copy of the table, predict the result of every
// accepted item in order, and compare each result strobe field by field with
// the oldest expected result. Run a short directed table first, then random traffic
// in phases with different amounts of sender idling.
module segment_protection_table_tb;

  localparam int unsigned TABLE_DEPTH  = spt_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned NUM_PHASES   = 4;
  // The slowest item is a full-table miss and the longest sender gap is set
  // by MAX_GAP; allow many times that with nothing moving.
  localparam int unsigned MAX_GAP      = 30;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PRINT_LIMIT  = 40;

  // Command codes the block does not decode: no effect, all result fields zero.
  localparam logic [spt_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [spt_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [spt_pkg::CMD_W-1:0]  command;
    logic [spt_pkg::SEL_W-1:0]  selector;
    logic [spt_pkg::PRIV_W-1:0] entry_priv;
    logic [spt_pkg::PERM_W-1:0] entry_perm;
    logic [spt_pkg::PRIV_W-1:0] proc_priv;
    logic [spt_pkg::PERM_W-1:0] access;
    logic [spt_pkg::FIDX_W-1:0] free_index;
    logic [spt_pkg::ADDR_W-1:0] base;
    logic [spt_pkg::ADDR_W-1:0] limit;
  } seg_cmd_t;

  typedef struct packed {
    logic [spt_pkg::STATUS_W-1:0] status;
    logic [spt_pkg::INDEX_W-1:0]  index;
    logic                         granted;
  } seg_resp_t;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct packed {
    seg_cmd_t  cmd;
    logic      typed;
    seg_resp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [spt_pkg::CMD_W-1:0]  in_command = '0;
  logic [spt_pkg::SEL_W-1:0]  in_seg_selector = '0;
  logic [spt_pkg::ADDR_W-1:0] in_seg_base = '0;
  logic [spt_pkg::ADDR_W-1:0] in_seg_limit = '0;
  logic [spt_pkg::PRIV_W-1:0] in_entry_privilege = '0;
  logic [spt_pkg::PERM_W-1:0] in_entry_permissions = '0;
  logic [spt_pkg::PRIV_W-1:0] in_process_privilege = '0;
  logic [spt_pkg::PERM_W-1:0] in_access_bits = '0;
  logic [spt_pkg::FIDX_W-1:0] in_free_index = '0;
  logic                         out_valid;
  logic [spt_pkg::STATUS_W-1:0] out_status;
  logic [spt_pkg::INDEX_W-1:0]  out_entry_index;
  logic                         out_access_granted;

  // Shadow table: fill count plus per-entry fields.
  logic [4:0]                 fill_count;
  logic [spt_pkg::SEL_W-1:0]  sel_tbl  [TABLE_DEPTH];
  logic [spt_pkg::ADDR_W-1:0] base_tbl [TABLE_DEPTH];
  logic [spt_pkg::ADDR_W-1:0] limit_tbl[TABLE_DEPTH];
  logic [spt_pkg::PRIV_W-1:0] priv_tbl [TABLE_DEPTH];
  logic [spt_pkg::PERM_W-1:0] perm_tbl [TABLE_DEPTH];

  seg_resp_t pending_results[$];
  int        error_count = 0;
  int        counted_items = 0;
  int        stall_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  segment_protection_table #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_seg_selector     (in_seg_selector),
    .in_seg_base         (in_seg_base),
    .in_seg_limit        (in_seg_limit),
    .in_entry_privilege  (in_entry_privilege),
    .in_entry_permissions(in_entry_permissions),
    .in_process_privilege(in_process_privilege),
    .in_access_bits      (in_access_bits),
    .in_free_index       (in_free_index),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index),
    .out_access_granted  (out_access_granted)
  );

  // ---------------------------------------------------------------------
  // Shadow table model
  // ---------------------------------------------------------------------

  // Empty the shadow table and zero every entry (reset and the clear command).
  function automatic void clear_table();
    fill_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_tbl[i]   = '0;
      base_tbl[i]  = '0;
      limit_tbl[i] = '0;
      priv_tbl[i]  = '0;
      perm_tbl[i]  = '0;
    end
  endfunction

  // First entry below the fill count holding sel, or -1. Freed entries
  // hold selector zero and still match it.
  function automatic int find_selector(logic [spt_pkg::SEL_W-1:0] sel);
    for (int i = 0; i < int'(fill_count); i++) begin
      if (sel_tbl[i] == sel) return i;
    end
    return -1;
  endfunction

  // Apply one accepted item to the shadow table and return its result.
  function automatic seg_resp_t apply_command(seg_cmd_t c);
    seg_resp_t r;
    int        hit;
    r = '0;
    r.status = spt_pkg::ST_OK;
    case (c.command)
      spt_pkg::CMD_CLEAR: clear_table();
      spt_pkg::CMD_ALLOC: begin
        // Fullness wins over a duplicate selector.
        if (int'(fill_count) >= TABLE_DEPTH) begin
          r.status = spt_pkg::ST_FULL;
        end else if (find_selector(c.selector) >= 0) begin
          r.status = spt_pkg::ST_DUP;
        end else begin
          sel_tbl[fill_count[3:0]]   = c.selector;
          base_tbl[fill_count[3:0]]  = c.base;
          limit_tbl[fill_count[3:0]] = c.limit;
          priv_tbl[fill_count[3:0]]  = c.entry_priv;
          perm_tbl[fill_count[3:0]]  = c.entry_perm;
          r.index = fill_count[3:0];
          fill_count = fill_count + 5'd1;
        end
      end
      spt_pkg::CMD_CHECK: begin
        hit = find_selector(c.selector);
        if (hit < 0) begin
          r.status = spt_pkg::ST_NOTFOUND;
        end else begin
          // A hit reports its index whether or not access is granted.
          r.index = spt_pkg::INDEX_W'(hit);
          r.granted = (c.proc_priv >= priv_tbl[hit]) &&
                      ((perm_tbl[hit] & c.access) == c.access);
        end
      end
      spt_pkg::CMD_FIND: begin
        hit = find_selector(c.selector);
        if (hit < 0) r.status = spt_pkg::ST_NOTFOUND;
        else r.index = spt_pkg::INDEX_W'(hit);
      end
      spt_pkg::CMD_FREE: begin
        // Zero only the selector; the fill count never shrinks.
        if (int'(c.free_index) < int'(fill_count)) sel_tbl[c.free_index[3:0]] = '0;
        else r.status = spt_pkg::ST_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic seg_cmd_t mk_cmd(logic [spt_pkg::CMD_W-1:0] command,
                                      logic [spt_pkg::SEL_W-1:0] sel,
                                      logic [spt_pkg::PRIV_W-1:0] epriv,
                                      logic [spt_pkg::PERM_W-1:0] eperm,
                                      logic [spt_pkg::PRIV_W-1:0] ppriv,
                                      logic [spt_pkg::PERM_W-1:0] acc,
                                      logic [spt_pkg::FIDX_W-1:0] fidx,
                                      logic [spt_pkg::ADDR_W-1:0] base,
                                      logic [spt_pkg::ADDR_W-1:0] limit);
    seg_cmd_t c;
    c.command    = command;
    c.selector   = sel;
    c.entry_priv = epriv;
    c.entry_perm = eperm;
    c.proc_priv  = ppriv;
    c.access     = acc;
    c.free_index = fidx;
    c.base       = base;
    c.limit      = limit;
    return c;
  endfunction

  function automatic dir_row_t exp_row(seg_cmd_t c, logic [spt_pkg::STATUS_W-1:0] st,
                                       logic [spt_pkg::INDEX_W-1:0] idx, logic g);
    dir_row_t row;
    row.cmd  = c;
    row.typed = 1'b1;
    row.want.status  = st;
    row.want.index   = idx;
    row.want.granted = g;
    return row;
  endfunction

  function automatic dir_row_t pred_row(seg_cmd_t c);
    dir_row_t row;
    row.cmd   = c;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // Half the time a live selector so lookups hit; a small pool with zero to force
  // duplicates and freed-entry matches; the rest anywhere in the range.
  function automatic logic [spt_pkg::SEL_W-1:0] pick_selector();
    int r;
    r = $urandom_range(99);
    if (fill_count != 0 && r < 50) return sel_tbl[$urandom_range(0, int'(fill_count) - 1)];
    if (r < 75) return spt_pkg::SEL_W'($urandom_range(0, 7));
    return spt_pkg::SEL_W'($urandom);
  endfunction

  function automatic logic [spt_pkg::CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 35) return spt_pkg::CMD_CHECK;
    if (r < 52) return spt_pkg::CMD_FIND;
    if (r < 72) return spt_pkg::CMD_ALLOC;
    if (r < 88) return spt_pkg::CMD_FREE;
    if (r < 91) return spt_pkg::CMD_CLEAR;
    return spt_pkg::CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
  endfunction

  // Random item of one kind; every field random, then shaped to reach hits.
  function automatic seg_cmd_t rand_cmd(logic [spt_pkg::CMD_W-1:0] command);
    seg_cmd_t c;
    int       hit;
    c = mk_cmd(command, pick_selector(), spt_pkg::PRIV_W'($urandom),
               spt_pkg::PERM_W'($urandom), spt_pkg::PRIV_W'($urandom),
               spt_pkg::PERM_W'($urandom), spt_pkg::FIDX_W'($urandom),
               spt_pkg::ADDR_W'($urandom), spt_pkg::ADDR_W'($urandom));
    if (command == spt_pkg::CMD_CHECK) begin
      hit = find_selector(c.selector);
      if (hit >= 0 && $urandom_range(99) < 60) begin
        // Sit near the privilege boundary and ask for a subset of the mask.
        c.proc_priv = priv_tbl[hit] + spt_pkg::PRIV_W'($urandom_range(0, 2))
                      - spt_pkg::PRIV_W'(1);
        c.access    = perm_tbl[hit] & spt_pkg::PERM_W'($urandom);
      end
    end
    if (command == spt_pkg::CMD_FREE && $urandom_range(99) < 75)
      c.free_index = spt_pkg::FIDX_W'($urandom_range(0, int'(fill_count)));
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------

  // Optionally idle, then present one item and hold it until accepted.
  // Queue its expected result at the accepting edge. Return in that time
  // step with start still high, so the caller either drives the next item
  // or drops start, with a single assignment either way.
  task automatic issue(seg_cmd_t c, int idle_pct, logic typed, seg_resp_t want);
    seg_resp_t predicted;
    int        gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = 0;
      do begin
        @(posedge clk);
        gap++;
      end while (gap < MAX_GAP && $urandom_range(99) < idle_pct);
    end
    start                <= 1'b1;
    in_command           <= c.command;
    in_seg_selector      <= c.selector;
    in_seg_base          <= c.base;
    in_seg_limit         <= c.limit;
    in_entry_privilege   <= c.entry_priv;
    in_entry_permissions <= c.entry_perm;
    in_process_privilege <= c.proc_priv;
    in_access_bits       <= c.access;
    in_free_index        <= c.free_index;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_command(c);
    pending_results.push_back(typed ? want : predicted);
    counted_items++;
  endtask

  // Drop start and hold until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One well-formed burst: maybe clear, fill (sometimes past full), then mix.
  task automatic run_episode(int idle_pct);
    seg_cmd_t c;
    int       fills;
    if ($urandom_range(99) < 30) issue(rand_cmd(spt_pkg::CMD_CLEAR), idle_pct, 1'b0, '0);
    fills = ($urandom_range(3) == 0) ? TABLE_DEPTH + 2 : $urandom_range(1, TABLE_DEPTH);
    repeat (fills) begin
      c = rand_cmd(spt_pkg::CMD_ALLOC);
      // Fresh selectors mostly, so the table really fills up.
      if ($urandom_range(99) < 85) c.selector = spt_pkg::SEL_W'($urandom);
      issue(c, idle_pct, 1'b0, '0);
    end
    repeat ($urandom_range(10, 40)) issue(rand_cmd(pick_command()), idle_pct, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (error_count < PRINT_LIMIT)
      $display("%0t ns: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
    error_count++;
  endtask

  // Take each strobed result at the edge that ends its cycle and compare it
  // with the oldest expected result.
  always @(posedge clk) begin
    seg_resp_t want_r;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", '0, 32'(out_status));
      end else begin
        want_r = pending_results.pop_front();
        if (out_status !== want_r.status)
          report_mismatch("status", 32'(want_r.status), 32'(out_status));
        if (out_entry_index !== want_r.index)
          report_mismatch("entry_index", 32'(want_r.index), 32'(out_entry_index));
        if (out_access_granted !== want_r.granted)
          report_mismatch("access_granted", 32'(want_r.granted), 32'(out_access_granted));
      end
    end
  end

  // Watchdog: end the run once the stall counter, cleared whenever an item or
  // a result moves, reaches STALL_LIMIT.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: watchdog, nothing moved for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    dir_row_t directed_rows[$];
    int       idle_pct[NUM_PHASES];

    // Phases: no idling, heavy idling, light idling, no idling again.
    idle_pct = '{0, 71, 28, 0};

    // Table starts empty. Entries after the allocations below:
    //   0: 0xFFFF priv 0xFF perm 0xFF   1: 0x0000 priv 0 perm 0
    //   2: 0x5A5A priv 0x10 perm 0xA5   3: 0xFFFF (after entry 0 is freed)
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FIND, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_NOTFOUND, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_CHECK, 16'h1234, 8'h00, 8'h00, 8'hFF,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_NOTFOUND, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FREE, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_RANGE, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_ALLOC, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), spt_pkg::ST_OK, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_ALLOC, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd1, 1'b0));
    // Duplicate selector
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_ALLOC, 16'hFFFF, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_DUP, 4'd0, 1'b0));
    // Grant at the top of both ranges, deny one step below the privilege.
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_CHECK, 16'hFFFF, 8'h00, 8'h00, 8'hFF,
      8'hFF, 8'h00, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd0, 1'b1));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_CHECK, 16'hFFFF, 8'h00, 8'h00, 8'hFE,
      8'h01, 8'h00, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd0, 1'b0));
    // Empty request at privilege zero grants; a missing bit denies.
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_CHECK, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd1, 1'b1));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_CHECK, 16'h0000, 8'h00, 8'h00, 8'hFF,
      8'h80, 8'h00, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd1, 1'b0));
    directed_rows.push_back(pred_row(mk_cmd(spt_pkg::CMD_ALLOC, 16'h5A5A, 8'h10, 8'hA5, 8'h00,
      8'h00, 8'h00, 32'h1234_5678, 32'h0000_FFFF)));
    directed_rows.push_back(pred_row(mk_cmd(spt_pkg::CMD_CHECK, 16'h5A5A, 8'h00, 8'h00, 8'h10,
      8'hA5, 8'h00, 32'h0, 32'h0)));
    directed_rows.push_back(pred_row(mk_cmd(spt_pkg::CMD_CHECK, 16'h5A5A, 8'h00, 8'h00, 8'h0F,
      8'h00, 8'h00, 32'h0, 32'h0)));
    directed_rows.push_back(pred_row(mk_cmd(spt_pkg::CMD_CHECK, 16'h5A5A, 8'h00, 8'h00, 8'h80,
      8'h5A, 8'h00, 32'h0, 32'h0)));
    // Free entry 0, then selector zero finds the freed slot first.
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FREE, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FIND, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FIND, 16'hFFFF, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_NOTFOUND, 4'd0, 1'b0));
    // The count never shrinks: the freed selector is appended at index 3.
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_ALLOC, 16'hFFFF, 8'h01, 8'h01, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd3, 1'b0));
    // Free out of range: far past the count, then exactly at the count.
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FREE, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hFF, 32'h0, 32'h0), spt_pkg::ST_RANGE, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FREE, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h04, 32'h0, 32'h0), spt_pkg::ST_RANGE, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FREE, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h03, 32'h0, 32'h0), spt_pkg::ST_OK, 4'd0, 1'b0));
    // Unknown codes with every field set: no effect, all result fields zero.
    directed_rows.push_back(exp_row(mk_cmd(CMD_UNUSED_FIRST, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF), spt_pkg::ST_OK, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(CMD_UNUSED_LAST, 16'h0000, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF), spt_pkg::ST_OK, 4'd0, 1'b0));
    // Clear, after which even selector zero is gone.
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_CLEAR, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), spt_pkg::ST_OK, 4'd0, 1'b0));
    directed_rows.push_back(exp_row(mk_cmd(spt_pkg::CMD_FIND, 16'h0000, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 32'h0, 32'h0), spt_pkg::ST_NOTFOUND, 4'd0, 1'b0));

    // Hold reset first; the block empties itself, so does the model.
    clear_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, 0, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic; drain fully at each phase boundary so the sender pauses
    // until every expected result has come.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      while (counted_items < (ph + 1) * RANDOM_ITEMS / NUM_PHASES)
        run_episode(idle_pct[ph]);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
